FILE: src/psm_pkg.sv
// Shared types and constants for the phrase-in-sentence matcher.
package psm_pkg;

    localparam int WORD_W             = 20;
    localparam int START_W            = 7;
    localparam int MAX_SENT_WORDS_DEF = 128;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_PHRASE = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] word;
        logic              last;
    } in_t;

    typedef struct packed {
        logic               matched;
        logic [START_W-1:0] match_start;
    } out_t;

endpackage

FILE: src/phrase_in_sentence_matcher.sv
// Phrase-in-sentence matcher top level: sentence store, candidate sweep, result register.
//
// Input channel (item_valid / item_stall / item) carries one transaction per word.
// op CLEAR empties the sentence, op APPEND stores a word at the sentence end (dropped
// once MAX_SENT_WORDS words are held); both abandon any phrase in progress.
// op PHRASE feeds the next phrase word; item.last marks the final one.
// Unused op codes are taken and ignored.
// Each phrase word is accepted and then the input stalls for one sweep over all
// start positions through the two memories (sentence words, candidate bits), one
// read per cycle with registered read data, followed by the drain and result states,
// before the next transaction can be taken.
// On the final phrase word one result transaction (matched, lowest match start) is
// loaded into the output register at the end of that word's result state.
// The output register decouples the sides: new items are accepted while a result
// waits. If a result is still stalled when the next one is ready, the block holds
// in its result state until the output register frees up.
// Reset empties the sentence and re-arms the phrase; no memory clearing pass is
// needed, since the first word of each phrase rewrites every candidate bit.
module phrase_in_sentence_matcher #(
    parameter int MAX_SENT_WORDS = psm_pkg::MAX_SENT_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  psm_pkg::in_t  item,
    output logic          res_valid,
    input  logic          res_stall,
    output psm_pkg::out_t res
);

    // address width, count width (holds MAX_SENT_WORDS), position width
    localparam int AW = (MAX_SENT_WORDS > 1) ? $clog2(MAX_SENT_WORDS) : 1;
    localparam int CW = $clog2(MAX_SENT_WORDS + 1);
    localparam int PW = CW + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_RES   = 2'd3;

    logic [1:0] state_reg, state_next;

    // sentence and phrase bookkeeping
    logic [CW-1:0] len_reg;
    logic [CW-1:0] offset_reg;
    logic [psm_pkg::WORD_W-1:0] word_reg;
    logic last_reg;

    // sweep issue side
    logic [AW-1:0] s_reg;
    logic [PW-1:0] pos;
    logic          pos_in_range;

    // data side, registered, in the cycle after the issue side
    logic          p1_valid_reg;
    logic [AW-1:0] p1_s_reg;
    logic          p1_in_range_reg;
    logic          keep;

    logic          found_reg;
    logic [AW-1:0] first_reg;

    // memories
    logic [psm_pkg::WORD_W-1:0] sent_mem [MAX_SENT_WORDS];
    logic                       cand_mem [MAX_SENT_WORDS];
    logic [psm_pkg::WORD_W-1:0] sent_rd_reg;
    logic                       cand_rd_reg;

    // output register
    logic          res_valid_reg;
    psm_pkg::out_t res_reg;

    logic accept;
    logic append_we;
    logic res_free;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign append_we  = accept && (item.op == psm_pkg::OP_APPEND)
                        && (len_reg < CW'(MAX_SENT_WORDS));
    assign res_free   = !res_valid_reg || !res_stall;

    assign pos          = PW'(s_reg) + PW'(offset_reg);
    assign pos_in_range = (pos < PW'(len_reg));

    // first word of a phrase treats every stored candidate as still alive
    assign keep = p1_in_range_reg && (sent_rd_reg == word_reg)
                  && ((offset_reg == '0) || cand_rd_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.op == psm_pkg::OP_PHRASE))
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (s_reg == AW'(MAX_SENT_WORDS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_RES;
            ST_RES:
            begin
                if (!last_reg || res_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            offset_reg    <= '0;
            s_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= (state_reg == ST_SWEEP);

            if (accept)
            begin
                case (item.op)
                    psm_pkg::OP_CLEAR:
                    begin
                        len_reg    <= '0;
                        offset_reg <= '0;
                    end
                    psm_pkg::OP_APPEND:
                    begin
                        if (append_we)
                            len_reg <= len_reg + CW'(1);
                        offset_reg <= '0;
                    end
                    psm_pkg::OP_PHRASE:
                    begin
                        s_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_SWEEP)
                s_reg <= s_reg + AW'(1);

            // lowest surviving start wins; sweep runs upward
            if (p1_valid_reg && keep && !found_reg)
                found_reg <= 1'b1;

            // a new result refills the register in the cycle the old one leaves
            if ((state_reg == ST_RES) && last_reg && res_free)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            if ((state_reg == ST_RES) && (!last_reg || res_free))
            begin
                if (last_reg)
                    offset_reg <= '0;
                else if (offset_reg < CW'(MAX_SENT_WORDS))
                    offset_reg <= offset_reg + CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= item.word;
            last_reg <= item.last;
        end
        p1_s_reg        <= s_reg;
        p1_in_range_reg <= pos_in_range;
        if (p1_valid_reg && keep && !found_reg)
            first_reg <= p1_s_reg;
        if ((state_reg == ST_RES) && last_reg && res_free)
        begin
            res_reg.matched     <= found_reg;
            res_reg.match_start <= found_reg ? psm_pkg::START_W'(first_reg) : '0;
        end
    end

    // sentence word store
    always_ff @(posedge clk)
    begin
        if (append_we)
            sent_mem[len_reg[AW-1:0]] <= item.word;
        sent_rd_reg <= sent_mem[pos[AW-1:0]];
    end

    // candidate bit store
    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
            cand_mem[p1_s_reg] <= keep;
        cand_rd_reg <= cand_mem[s_reg];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/psm_checker.sv
// Port-level checker for the phrase-in-sentence matcher, with its bind.
module psm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_stall,
    input psm_pkg::in_t  item,
    input logic          res_valid,
    input logic          res_stall,
    input psm_pkg::out_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("stalled result changed");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.matched |-> res.match_start == '0)
        else $error("match_start nonzero without a match");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall))
        else $error("input stalled without an accepted transaction");

    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_stall))
        else $error("result appeared outside a phrase word");

endmodule

bind phrase_in_sentence_matcher psm_checker u_psm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);
